// File: design/wlba_pkg.sv
// Shared types and constants for the wear-leveling block allocator.
`timescale 1ns / 1ps
package wlba_pkg;

   typedef logic [1:0] mode_type;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT    = 2'd2;

   // leveling modes; the unused code behaves as dynamic only
   localparam mode_type MODE_NONE    = 2'd0;
   localparam mode_type MODE_DYNAMIC = 2'd1;
   localparam mode_type MODE_STATIC  = 2'd2;

   // result and register field widths
   localparam int BLOCK_W    = 3;
   localparam int WEAR_OUT_W = 16;
   localparam int INTERVAL_W = 10;

   // register reset values
   localparam mode_type                RESET_MODE     = MODE_STATIC;
   localparam logic [INTERVAL_W-1:0]   RESET_INTERVAL = 10'd5;
   localparam logic [WEAR_OUT_W-1:0]   RESET_LIMIT    = 16'd100;

endpackage

// File: design/wlba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wlba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/wlba_alu.sv
// Shared wear compare and saturating increment unit.
`timescale 1ns / 1ps
module wlba_alu #(
   parameter int WEAR_WIDTH = 16
) (
   input  logic [WEAR_WIDTH-1:0] cmp_a,
   input  logic [WEAR_WIDTH-1:0] cmp_b,
   input  logic [WEAR_WIDTH-1:0] inc_src,
   output logic                  lt,
   output logic [WEAR_WIDTH-1:0] inc_sum
);

   assign lt      = (cmp_a < cmp_b);
   // counts stop at all ones
   assign inc_sum = (inc_src == '1) ? inc_src : inc_src + WEAR_WIDTH'(1);

endmodule

// File: design/wear_leveling_block_allocator.sv
// Top level of the wear-leveling block allocator: sequencer, state and result registers.
`timescale 1ns / 1ps
// A request is taken only while idle; its strobe follows the dynamic scan and the wear bump,
// and also a static scan and two bumps when a static leveling step runs and finds both blocks.
// No new request is taken until the strobe is given and busy falls; each pass reads the
// wear RAM once per block through its single read port, one shared comparator deciding.
// Reset (synchronous): wear counts read as zero, cold marks set from INITIAL_WARM up,
// registers to mode 2 / interval 5 / limit 100. No clearing pass; the receiver cannot stall.
module wear_leveling_block_allocator #(
   parameter int NUM_BLOCKS   = 8,
   parameter int INITIAL_WARM = 5,
   parameter int WEAR_WIDTH   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_write_request,
   output logic                                 rsp_strobe,
   output logic [wlba_pkg::BLOCK_W-1:0]         rsp_chosen_block,
   output logic [wlba_pkg::WEAR_OUT_W-1:0]      rsp_chosen_wear,
   output logic                                 rsp_static_done,
   output logic [wlba_pkg::BLOCK_W-1:0]         rsp_static_source,
   output logic [wlba_pkg::BLOCK_W-1:0]         rsp_static_target,
   output logic                                 rsp_limit_reached,
   input  logic                                 csr_write_enable,
   input  logic [wlba_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wlba_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int INT_W = wlba_pkg::INTERVAL_W;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DSCAN  = 3'd1; // least-worn warm block
   localparam logic [2:0] S_DBUMP  = 3'd2; // count the host write
   localparam logic [2:0] S_SSCAN  = 3'd3; // least-worn cold and most-worn warm
   localparam logic [2:0] S_SBUMPC = 3'd4; // cold block turns warm
   localparam logic [2:0] S_SBUMPW = 3'd5; // warm block turns cold
   localparam logic [2:0] S_DONE   = 3'd6; // result strobe

   // control state
   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  found_ff, found_in;
   logic                  have_w_ff, have_w_in;
   logic [NUM_BLOCKS-1:0] valid_ff, valid_in;
   logic [NUM_BLOCKS-1:0] cold_ff, cold_in;
   logic [INT_W-1:0]      wss_ff, wss_in;
   logic [WEAR_WIDTH-1:0] highest_ff, highest_in;
   wlba_pkg::mode_type    mode_ff, mode_in;
   logic [INT_W-1:0]      interval_ff, interval_in;
   logic [wlba_pkg::WEAR_OUT_W-1:0] limit_ff, limit_in;

   // payload
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [WEAR_WIDTH-1:0] best_wear_ff, best_wear_in;
   logic [IDX_W-1:0]      wmax_idx_ff, wmax_idx_in;
   logic [WEAR_WIDTH-1:0] wmax_wear_ff, wmax_wear_in;
   logic [WEAR_WIDTH-1:0] w0_ff, w0_in;
   logic [wlba_pkg::BLOCK_W-1:0]    blk_ff, blk_in;
   logic [wlba_pkg::WEAR_OUT_W-1:0] wear_ff, wear_in;
   logic                            sdone_ff, sdone_in;
   logic [wlba_pkg::BLOCK_W-1:0]    src_ff, src_in;
   logic [wlba_pkg::BLOCK_W-1:0]    tgt_ff, tgt_in;

   // RAM and shared unit
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [WEAR_WIDTH-1:0] ram_wdata;
   logic [WEAR_WIDTH-1:0] ram_q;
   logic [WEAR_WIDTH-1:0] cmp_a, cmp_b, inc_src, inc_sum;
   logic                  lt;

   // scan element and helpers
   logic [WEAR_WIDTH-1:0] elem;
   logic                  elem_cold;
   logic                  cand_dyn;
   logic                  scan_last;
   logic [IDX_W-1:0]      dyn_idx;
   logic [INT_W:0]        wss_next;
   logic [INT_W-1:0]      interval_eff;
   logic                  fire;
   logic [31:0]           dyn_idx_ext, best_idx_ext, wmax_idx_ext, inc_ext;
   logic [31:0]           highest_ext, limit_ext;

   wlba_ram #(
      .WIDTH (WEAR_WIDTH),
      .DEPTH (NUM_BLOCKS)
   ) u_wear_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (ram_q)
   );

   wlba_alu #(
      .WEAR_WIDTH (WEAR_WIDTH)
   ) u_alu (
      .cmp_a   (cmp_a),
      .cmp_b   (cmp_b),
      .inc_src (inc_src),
      .lt      (lt),
      .inc_sum (inc_sum)
   );

   // unwritten entries read as zero
   assign elem      = valid_ff[rd_idx_ff] ? ram_q : '0;
   assign elem_cold = cold_ff[rd_idx_ff];
   // mode 0 only ever considers block 0
   assign cand_dyn  = (mode_ff == wlba_pkg::MODE_NONE) ? (rd_idx_ff == '0) : !elem_cold;
   assign scan_last = (cnt_ff == CNT_W'(NUM_BLOCKS));
   // no candidate found: fall back to block 0
   assign dyn_idx   = found_ff ? best_idx_ff : '0;

   assign wss_next     = {1'b0, wss_ff} + (INT_W + 1)'(1);
   assign interval_eff = (interval_ff == '0) ? INT_W'(1) : interval_ff;
   assign fire         = (wss_next >= {1'b0, interval_eff});

   assign dyn_idx_ext  = 32'(dyn_idx);
   assign best_idx_ext = 32'(best_idx_ff);
   assign wmax_idx_ext = 32'(wmax_idx_ff);
   assign inc_ext      = 32'(inc_sum);
   assign highest_ext  = 32'(highest_ff);
   assign limit_ext    = 32'(limit_ff);

   // operand steering for the shared unit
   always_comb begin
      cmp_a   = elem;
      cmp_b   = best_wear_ff;
      inc_src = best_wear_ff;
      case (state_ff)
         S_SSCAN: begin
            if (!elem_cold) begin
               cmp_a = wmax_wear_ff;
               cmp_b = elem;
            end
         end
         S_DBUMP: begin
            cmp_a   = highest_ff;
            cmp_b   = inc_sum;
            inc_src = found_ff ? best_wear_ff : w0_ff;
         end
         S_SBUMPC: begin
            cmp_a   = highest_ff;
            cmp_b   = inc_sum;
            inc_src = best_wear_ff;
         end
         S_SBUMPW: begin
            cmp_a   = highest_ff;
            cmp_b   = inc_sum;
            inc_src = wmax_wear_ff;
         end
         default: begin
            cmp_a = elem;
         end
      endcase
   end

   // sequencer and next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = cnt_ff[IDX_W-1:0];
      found_in     = found_ff;
      have_w_in    = have_w_ff;
      valid_in     = valid_ff;
      cold_in      = cold_ff;
      wss_in       = wss_ff;
      highest_in   = highest_ff;
      best_idx_in  = best_idx_ff;
      best_wear_in = best_wear_ff;
      wmax_idx_in  = wmax_idx_ff;
      wmax_wear_in = wmax_wear_ff;
      w0_in        = w0_ff;
      blk_in       = blk_ff;
      wear_in      = wear_ff;
      sdone_in     = sdone_ff;
      src_in       = src_ff;
      tgt_in       = tgt_ff;
      ram_we       = 1'b0;
      ram_waddr    = best_idx_ff;
      ram_wdata    = inc_sum;

      case (state_ff)
         S_IDLE: begin
            if (start && req_write_request) begin
               state_in  = S_DSCAN;
               cnt_in    = '0;
               found_in  = 1'b0;
               have_w_in = 1'b0;
            end
         end
         S_DSCAN: begin
            // one read issued per cycle, its data compared in the next cycle
            cnt_in    = cnt_ff + CNT_W'(1);
            rd_vld_in = (cnt_ff < CNT_W'(NUM_BLOCKS));
            if (rd_vld_ff) begin
               if (rd_idx_ff == '0) begin
                  w0_in = elem;
               end
               // strict compare keeps the lowest index on a tie
               if (cand_dyn && (!found_ff || lt)) begin
                  found_in     = 1'b1;
                  best_idx_in  = rd_idx_ff;
                  best_wear_in = elem;
               end
            end
            if (scan_last) begin
               state_in = S_DBUMP;
            end
         end
         S_DBUMP: begin
            ram_we             = 1'b1;
            ram_waddr          = dyn_idx;
            valid_in[dyn_idx]  = 1'b1;
            if (lt) begin
               highest_in = inc_sum;
            end
            blk_in   = dyn_idx_ext[wlba_pkg::BLOCK_W-1:0];
            wear_in  = inc_ext[wlba_pkg::WEAR_OUT_W-1:0];
            sdone_in = 1'b0;
            src_in   = '0;
            tgt_in   = '0;
            if (fire) begin
               wss_in = '0;
            end else begin
               wss_in = wss_next[INT_W-1:0];
            end
            if (fire && (mode_ff == wlba_pkg::MODE_STATIC)) begin
               state_in  = S_SSCAN;
               cnt_in    = '0;
               found_in  = 1'b0;
               have_w_in = 1'b0;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SSCAN: begin
            // cold blocks feed the minimum, warm blocks the maximum
            cnt_in    = cnt_ff + CNT_W'(1);
            rd_vld_in = (cnt_ff < CNT_W'(NUM_BLOCKS));
            if (rd_vld_ff) begin
               if (elem_cold && (!found_ff || lt)) begin
                  found_in     = 1'b1;
                  best_idx_in  = rd_idx_ff;
                  best_wear_in = elem;
               end
               if (!elem_cold && (!have_w_ff || lt)) begin
                  have_w_in    = 1'b1;
                  wmax_idx_in  = rd_idx_ff;
                  wmax_wear_in = elem;
               end
            end
            // the last block is compared in this same cycle
            if (scan_last) begin
               state_in = (found_in && have_w_in) ? S_SBUMPC : S_DONE;
            end
         end
         S_SBUMPC: begin
            ram_we                = 1'b1;
            ram_waddr             = best_idx_ff;
            valid_in[best_idx_ff] = 1'b1;
            cold_in[best_idx_ff]  = 1'b0;
            if (lt) begin
               highest_in = inc_sum;
            end
            state_in = S_SBUMPW;
         end
         S_SBUMPW: begin
            ram_we                = 1'b1;
            ram_waddr             = wmax_idx_ff;
            valid_in[wmax_idx_ff] = 1'b1;
            cold_in[wmax_idx_ff]  = 1'b1;
            if (lt) begin
               highest_in = inc_sum;
            end
            sdone_in = 1'b1;
            src_in   = best_idx_ext[wlba_pkg::BLOCK_W-1:0];
            tgt_in   = wmax_idx_ext[wlba_pkg::BLOCK_W-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration writes, which the user must make only while idle; the block leaves this unchecked
   always_comb begin
      mode_in     = mode_ff;
      interval_in = interval_ff;
      limit_in    = limit_ff;
      if (csr_write_enable) begin
         case (csr_index)
            wlba_pkg::CSR_MODE:     mode_in     = csr_write_data[1:0];
            wlba_pkg::CSR_INTERVAL: interval_in = csr_write_data[INT_W-1:0];
            wlba_pkg::CSR_LIMIT:    limit_in    = csr_write_data;
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         found_ff    <= 1'b0;
         have_w_ff   <= 1'b0;
         valid_ff    <= '0;
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            cold_ff[i] <= (i >= INITIAL_WARM);
         end
         wss_ff      <= '0;
         highest_ff  <= '0;
         mode_ff     <= wlba_pkg::RESET_MODE;
         interval_ff <= wlba_pkg::RESET_INTERVAL;
         limit_ff    <= wlba_pkg::RESET_LIMIT;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         rd_vld_ff   <= rd_vld_in;
         found_ff    <= found_in;
         have_w_ff   <= have_w_in;
         valid_ff    <= valid_in;
         cold_ff     <= cold_in;
         wss_ff      <= wss_in;
         highest_ff  <= highest_in;
         mode_ff     <= mode_in;
         interval_ff <= interval_in;
         limit_ff    <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      best_idx_ff  <= best_idx_in;
      best_wear_ff <= best_wear_in;
      wmax_idx_ff  <= wmax_idx_in;
      wmax_wear_ff <= wmax_wear_in;
      w0_ff        <= w0_in;
      blk_ff       <= blk_in;
      wear_ff      <= wear_in;
      sdone_ff     <= sdone_in;
      src_ff       <= src_in;
      tgt_ff       <= tgt_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = (state_ff == S_DONE);
   assign rsp_chosen_block  = blk_ff;
   assign rsp_chosen_wear   = wear_ff;
   assign rsp_static_done   = sdone_ff;
   assign rsp_static_source = src_ff;
   assign rsp_static_target = tgt_ff;
   assign rsp_limit_reached = (highest_ext >= limit_ext);

endmodule

// File: design/wlba_checker.sv
// Port-level checks for the wear-leveling block allocator, bound to the top level.
`timescale 1ns / 1ps
module wlba_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_write_request,
   input logic                         rsp_strobe,
   input logic                         rsp_static_done,
   input logic [wlba_pkg::BLOCK_W-1:0] rsp_static_source,
   input logic [wlba_pkg::BLOCK_W-1:0] rsp_static_target
);

   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a request");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe not followed by idle");

   a_request_taken: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_write_request) |=> busy && !rsp_strobe)
      else $error("accepted request did not start work");

   a_static_fields_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_static_done) |->
         (rsp_static_source == '0) && (rsp_static_target == '0))
      else $error("static fields set without a static step");

endmodule

bind wear_leveling_block_allocator wlba_checker u_wlba_checker (.*);
